@@ design/lcd_pkg.sv @@
package lcd_pkg;

    // Default width of the line length counter and of the stored limit.
    localparam int LENGTH_BITS_DEF = 11;

    // Width of the configuration write data and the reset value of the limit.
    localparam int CFG_WIDTH = 11;
    localparam logic [CFG_WIDTH-1:0] MAX_LEN_RESET = 11'd1999;

    // Command candidates, one match flag each.
    localparam int NUM_CANDS = 7;
    localparam int CAND_OFF = 0;
    localparam int CAND_STOP = 1;
    localparam int CAND_START = 2;
    localparam int CAND_SCALE_F = 3;
    localparam int CAND_SCALE_C = 4;
    localparam int CAND_LOG = 5;
    localparam int CAND_PERIOD = 6;

    localparam int CAND_TEXT_DEPTH = 8;
    localparam int CAND_IDX_BITS = $clog2(CAND_TEXT_DEPTH);

    localparam logic [2:0] CAND_LEN [NUM_CANDS] = '{3'd3, 3'd4, 3'd5, 3'd7, 3'd7, 3'd3, 3'd7};

    localparam logic [7:0] CAND_TEXT [NUM_CANDS][CAND_TEXT_DEPTH] = '{
        '{"O", "F", "F", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"S", "T", "O", "P", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"S", "T", "A", "R", "T", 8'h00, 8'h00, 8'h00},
        '{"S", "C", "A", "L", "E", "=", "F", 8'h00},
        '{"S", "C", "A", "L", "E", "=", "C", 8'h00},
        '{"L", "O", "G", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"P", "E", "R", "I", "O", "D", "=", 8'h00}
    };

    // The number after PERIOD= starts at this character position.
    localparam int NUM_START = 7;

    // Magnitude limit of the number accumulator and the positive limit.
    localparam logic [15:0] ACCUM_LIMIT = 16'd32768;
    localparam logic [15:0] POS_LIMIT = 16'd32767;

    // Characters with a meaning of their own.
    localparam logic [7:0] CHAR_NUL = 8'h00;
    localparam logic [7:0] CHAR_TAB = 8'h09;
    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    typedef enum logic [3:0] {
        CMD_OFF = 4'd0,
        CMD_STOP = 4'd1,
        CMD_START = 4'd2,
        CMD_SCALE_F = 4'd3,
        CMD_SCALE_C = 4'd4,
        CMD_LOG = 4'd5,
        CMD_PERIOD = 4'd6,
        CMD_UNKNOWN = 4'd7,
        CMD_OVERFLOW = 4'd8
    } lcd_cmd_t;

    typedef enum logic [1:0] {
        PH_BLANKS = 2'd0,
        PH_DIGITS = 2'd1,
        PH_DONE = 2'd2
    } lcd_phase_t;

    typedef struct packed {
        lcd_cmd_t command;
        logic signed [15:0] period_value;
        logic stopped;
        logic scale_celsius;
    } lcd_result_t;

endpackage

@@ design/lcd_in_stage.sv @@
module lcd_in_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [7:0] in_byte,
    input  logic       take,
    output logic       in_ready,
    output logic       full,
    output logic [7:0] byte_out
);

    logic       full_reg;
    logic       full_next;
    logic [7:0] byte_reg;

    // The register accepts a new transaction when empty or when it is
    // being emptied in this same cycle.
    assign in_ready = !full_reg || take;

    always_comb
    begin
        full_next = full_reg;
        if (in_valid && in_ready)
        begin
            full_next = 1'b1;
        end
        else if (take)
        begin
            full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= in_byte;
        end
    end

    assign full = full_reg;
    assign byte_out = byte_reg;

endmodule

@@ design/lcd_parser.sv @@
module lcd_parser #(
    parameter int LENGTH_BITS = lcd_pkg::LENGTH_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [lcd_pkg::CFG_WIDTH-1:0]  cfg_wdata,
    input  logic                           step,
    input  logic [7:0]                     byte_in,
    output logic                           res_valid,
    output lcd_pkg::lcd_result_t           res
);

    logic [LENGTH_BITS-1:0]           max_len_reg;
    logic [LENGTH_BITS-1:0]           len_reg;
    logic [LENGTH_BITS-1:0]           len_next;
    logic [lcd_pkg::NUM_CANDS-1:0]    match_reg;
    logic [lcd_pkg::NUM_CANDS-1:0]    match_next;
    lcd_pkg::lcd_phase_t              phase_reg;
    lcd_pkg::lcd_phase_t              phase_next;
    logic                             neg_reg;
    logic                             neg_next;
    logic [15:0]                      accum_reg;
    logic [15:0]                      accum_next;
    logic                             ovf_reg;
    logic                             ovf_next;
    logic                             stop_reg;
    logic                             stop_next;
    logic                             cels_reg;
    logic                             cels_next;
    logic [15:0]                      period_reg;
    logic [15:0]                      period_next;

    logic [lcd_pkg::NUM_CANDS-1:0]    hit;
    logic                             is_digit;
    logic [3:0]                       digit_val;
    logic [18:0]                      accum_grown;
    logic [15:0]                      num_value;
    logic                             emit;
    lcd_pkg::lcd_cmd_t                code;

    assign is_digit = (byte_in >= lcd_pkg::CHAR_ZERO) && (byte_in <= lcd_pkg::CHAR_NINE);
    assign digit_val = 4'(byte_in - lcd_pkg::CHAR_ZERO);
    // accum * 10 + digit, built from two shifts.
    assign accum_grown = {accum_reg, 3'b000} + {2'b00, accum_reg, 1'b0} + {15'd0, digit_val};
    assign num_value = neg_reg ? (16'd0 - accum_reg)
                               : ((accum_reg > lcd_pkg::POS_LIMIT) ? lcd_pkg::POS_LIMIT
                                                                   : accum_reg);

    // A candidate is complete when its flag survived and the length fits:
    // exact for most, at least three for LOG, past the '=' for PERIOD.
    always_comb
    begin
        for (int k = 0; k < lcd_pkg::NUM_CANDS; k++)
        begin
            if (k == lcd_pkg::CAND_LOG)
            begin
                hit[k] = match_reg[k]
                         && (len_reg >= LENGTH_BITS'(lcd_pkg::CAND_LEN[k]));
            end
            else if (k == lcd_pkg::CAND_PERIOD)
            begin
                hit[k] = match_reg[k]
                         && (len_reg > LENGTH_BITS'(lcd_pkg::CAND_LEN[k]));
            end
            else
            begin
                hit[k] = match_reg[k]
                         && (len_reg == LENGTH_BITS'(lcd_pkg::CAND_LEN[k]));
            end
        end
    end

    always_comb
    begin
        len_next = len_reg;
        match_next = match_reg;
        phase_next = phase_reg;
        neg_next = neg_reg;
        accum_next = accum_reg;
        ovf_next = ovf_reg;
        stop_next = stop_reg;
        cels_next = cels_reg;
        period_next = period_reg;
        emit = 1'b0;
        code = lcd_pkg::CMD_UNKNOWN;

        if (step && (byte_in != lcd_pkg::CHAR_NUL))
        begin
            if (byte_in == lcd_pkg::CHAR_LF)
            begin
                if (!ovf_reg)
                begin
                    emit = 1'b1;
                    if (hit[lcd_pkg::CAND_OFF])
                    begin
                        code = lcd_pkg::CMD_OFF;
                    end
                    else if (hit[lcd_pkg::CAND_STOP])
                    begin
                        code = lcd_pkg::CMD_STOP;
                        stop_next = 1'b1;
                    end
                    else if (hit[lcd_pkg::CAND_START])
                    begin
                        code = lcd_pkg::CMD_START;
                        stop_next = 1'b0;
                    end
                    else if (hit[lcd_pkg::CAND_SCALE_F])
                    begin
                        code = lcd_pkg::CMD_SCALE_F;
                        cels_next = 1'b0;
                    end
                    else if (hit[lcd_pkg::CAND_SCALE_C])
                    begin
                        code = lcd_pkg::CMD_SCALE_C;
                        cels_next = 1'b1;
                    end
                    else if (hit[lcd_pkg::CAND_LOG])
                    begin
                        code = lcd_pkg::CMD_LOG;
                    end
                    else if (hit[lcd_pkg::CAND_PERIOD])
                    begin
                        code = lcd_pkg::CMD_PERIOD;
                        period_next = num_value;
                    end
                end
                // Every newline starts a fresh line.
                len_next = '0;
                match_next = '1;
                phase_next = lcd_pkg::PH_BLANKS;
                neg_next = 1'b0;
                accum_next = '0;
                ovf_next = 1'b0;
            end
            else if (ovf_reg)
            begin
                // Rest of an overlong line is thrown away.
            end
            else if ((len_reg == '0)
                     && ((byte_in == lcd_pkg::CHAR_SPACE) || (byte_in == lcd_pkg::CHAR_TAB)))
            begin
                // Leading blanks are dropped.
            end
            else if (len_reg >= max_len_reg)
            begin
                ovf_next = 1'b1;
                emit = 1'b1;
                code = lcd_pkg::CMD_OVERFLOW;
            end
            else
            begin
                for (int k = 0; k < lcd_pkg::NUM_CANDS; k++)
                begin
                    if (len_reg < LENGTH_BITS'(lcd_pkg::CAND_LEN[k]))
                    begin
                        if (lcd_pkg::CAND_TEXT[k][len_reg[lcd_pkg::CAND_IDX_BITS-1:0]] != byte_in)
                        begin
                            match_next[k] = 1'b0;
                        end
                    end
                    else if ((k != lcd_pkg::CAND_LOG) && (k != lcd_pkg::CAND_PERIOD))
                    begin
                        match_next[k] = 1'b0;
                    end
                end

                if (len_reg >= LENGTH_BITS'(lcd_pkg::NUM_START))
                begin
                    case (phase_reg)
                        lcd_pkg::PH_BLANKS:
                        begin
                            if (byte_in inside {lcd_pkg::CHAR_SPACE,
                                                [lcd_pkg::CHAR_TAB:lcd_pkg::CHAR_CR]})
                            begin
                                phase_next = lcd_pkg::PH_BLANKS;
                            end
                            else if ((byte_in == lcd_pkg::CHAR_PLUS)
                                     || (byte_in == lcd_pkg::CHAR_MINUS))
                            begin
                                neg_next = (byte_in == lcd_pkg::CHAR_MINUS);
                                phase_next = lcd_pkg::PH_DIGITS;
                            end
                            else if (is_digit)
                            begin
                                accum_next = {12'd0, digit_val};
                                phase_next = lcd_pkg::PH_DIGITS;
                            end
                            else
                            begin
                                phase_next = lcd_pkg::PH_DONE;
                            end
                        end
                        lcd_pkg::PH_DIGITS:
                        begin
                            if (is_digit)
                            begin
                                accum_next = (accum_grown > {3'd0, lcd_pkg::ACCUM_LIMIT})
                                             ? lcd_pkg::ACCUM_LIMIT : accum_grown[15:0];
                            end
                            else
                            begin
                                phase_next = lcd_pkg::PH_DONE;
                            end
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase
                end

                len_next = len_reg + LENGTH_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= LENGTH_BITS'(lcd_pkg::MAX_LEN_RESET);
            len_reg <= '0;
            match_reg <= '1;
            phase_reg <= lcd_pkg::PH_BLANKS;
            neg_reg <= 1'b0;
            accum_reg <= '0;
            ovf_reg <= 1'b0;
            stop_reg <= 1'b0;
            cels_reg <= 1'b0;
            period_reg <= 16'd1;
        end
        else
        begin
            if (cfg_we)
            begin
                max_len_reg <= LENGTH_BITS'(cfg_wdata);
            end
            len_reg <= len_next;
            match_reg <= match_next;
            phase_reg <= phase_next;
            neg_reg <= neg_next;
            accum_reg <= accum_next;
            ovf_reg <= ovf_next;
            stop_reg <= stop_next;
            cels_reg <= cels_next;
            period_reg <= period_next;
        end
    end

    // The result carries the flags and period as they stand after the line.
    assign res_valid = emit;
    assign res.command = code;
    assign res.period_value = period_next;
    assign res.stopped = stop_next;
    assign res.scale_celsius = cels_next;

    a_nul_ignored: assert property (@(posedge clk) disable iff (!rst_n)
        (step && (byte_in == lcd_pkg::CHAR_NUL)) |=> $stable(len_reg) && $stable(match_reg))
        else $error("NUL byte changed the line state");

    a_overflow_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res.command == lcd_pkg::CMD_OVERFLOW)) |=> ovf_reg)
        else $error("overflow report without the overflow flag set");

    a_discard_silent: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> !res_valid)
        else $error("result produced while discarding an overlong line");

    a_accum_bound: assert property (@(posedge clk) disable iff (!rst_n)
        accum_reg <= lcd_pkg::ACCUM_LIMIT)
        else $error("number accumulator above its saturation limit");

endmodule

@@ design/lcd_out_stage.sv @@
module lcd_out_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  lcd_pkg::lcd_result_t  res,
    input  logic                  out_ready,
    output logic                  free,
    output logic                  out_valid,
    output lcd_pkg::lcd_result_t  out_res
);

    logic                  valid_reg;
    logic                  valid_next;
    lcd_pkg::lcd_result_t  res_reg;

    // Space for a new result whenever the register is empty or drains now.
    assign free = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res = res_reg;

endmodule

@@ design/line_command_decoder_top.sv @@
// Channel  Dir  Handshake              Payload
// input    in   in_valid / in_ready    rx_byte[7:0]
// result   out  out_valid / out_ready  command, period_value, stopped, scale_celsius
// config   in   cfg_we, no wait        cfg_wdata[10:0], the line length limit
//
// A byte is held in the input register and then passes the parser into the result register,
// from which its result can be taken once the parser has stepped on that byte.
// A new byte is accepted every cycle while the result register is not stalled.
// Reset (rst_n, asynchronous, active low) empties both registers and restores the limit
// of 1999, period 1, Fahrenheit and not stopped.
// A stalled result register holds the parser, and in_ready drops once one byte waits.
module line_command_decoder_top #(
    parameter int LENGTH_BITS = lcd_pkg::LENGTH_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [lcd_pkg::CFG_WIDTH-1:0] cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    rx_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [3:0]                    command,
    output logic signed [15:0]            period_value,
    output logic                          stopped,
    output logic                          scale_celsius
);

    logic                  in_full;
    logic [7:0]            held_byte;
    logic                  out_free;
    logic                  step;
    logic                  res_valid;
    lcd_pkg::lcd_result_t  res;
    lcd_pkg::lcd_result_t  out_res;

    // A byte moves from the input register through the parser whenever the
    // result register can take whatever that byte produces. Most bytes
    // produce nothing, but the decision is made before the byte is decoded,
    // so the parser only advances with room downstream.
    assign step = in_full && out_free;

    lcd_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_byte  (rx_byte),
        .take     (step),
        .in_ready (in_ready),
        .full     (in_full),
        .byte_out (held_byte)
    );

    // The parser keeps the whole line state: length, candidate match flags,
    // the PERIOD= number, the overflow flag and the persistent settings.
    lcd_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .step      (step),
        .byte_in   (held_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    lcd_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_valid),
        .res       (res),
        .out_ready (out_ready),
        .free      (out_free),
        .out_valid (out_valid),
        .out_res   (out_res)
    );

    assign command = out_res.command;
    assign period_value = out_res.period_value;
    assign stopped = out_res.stopped;
    assign scale_celsius = out_res.scale_celsius;

endmodule
